### rtl/cil_pkg.sv
// Shared types and constants for the CAN identifier learning table.
`default_nettype none
package cil_pkg;

  localparam int IDENT_W   = 11;
  localparam int LENGTH_W  = 4;
  localparam int PAYLOAD_W = 64;
  localparam int HITS_W    = 32;
  localparam int INDEX_W   = 8;
  localparam int USED_W    = 9;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [HITS_W-1:0] HITS_FIRST = 32'd1;

  typedef struct packed {
    logic [IDENT_W-1:0]   ident;
    logic [LENGTH_W-1:0]  length;
    logic [PAYLOAD_W-1:0] payload;
    logic [HITS_W-1:0]    hits;
  } entry_t;

  typedef struct packed {
    logic                 kind;
    logic                 frame_extended;
    logic [IDENT_W-1:0]   frame_ident;
    logic [LENGTH_W-1:0]  frame_length;
    logic [PAYLOAD_W-1:0] frame_payload;
    logic [INDEX_W-1:0]   read_index;
  } cmd_t;

  typedef struct packed {
    logic                 added_new;
    logic                 updated_existing;
    logic                 dropped;
    logic                 read_valid;
    logic [IDENT_W-1:0]   entry_ident;
    logic [LENGTH_W-1:0]  entry_length;
    logic [PAYLOAD_W-1:0] entry_payload;
    logic [HITS_W-1:0]    entry_hits;
    logic [USED_W-1:0]    entries_used;
  } rsp_t;

endpackage
`default_nettype wire

### rtl/cil_cell.sv
// One table slot: holds an entry and loads its neighbor's entry on shift.
`default_nettype none
module cil_cell (
  input  wire logic          clk,
  input  wire logic          shift,
  input  wire cil_pkg::entry_t d,
  output cil_pkg::entry_t    q
);
  import cil_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule
`default_nettype wire

### rtl/cil_ring.sv
// Ring of slot cells; entries move one cell toward the head per shift.
`default_nettype none
module cil_ring #(
  parameter int TABLE_SLOTS = 256
) (
  input  wire logic            clk,
  input  wire logic            shift,
  input  wire cil_pkg::entry_t tail,
  output cil_pkg::entry_t      head
);
  import cil_pkg::*;

  entry_t q [TABLE_SLOTS];
  entry_t d [TABLE_SLOTS];

  for (genvar k = 0; k < TABLE_SLOTS; k++) begin : g_cell
    if (k == TABLE_SLOTS - 1) begin : g_tail
      assign d[k] = tail;
    end else begin : g_mid
      assign d[k] = q[k+1];
    end
    cil_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .d     (d[k]),
      .q     (q[k])
    );
  end

  assign head = q[0];

endmodule
`default_nettype wire

### rtl/can_id_learning_table_top.sv
// Top level of the CAN identifier learning table: control and slot ring.
//
//  channel   direction  handshake                      word
//  command   in         start, taken when !busy        cmd  (cil_pkg::cmd_t)
//  result    out        done, one-cycle strobe         rsp  (cil_pkg::rsp_t)
//
// Flow: an extended frame gives its result in the cycle after it is taken.
//   Every other item rotates the whole ring once (one slot per cycle past
//   the head compare/update point), then forms the result in S_FIN, from
//   which done is registered; the next command can be taken in the same
//   cycle that done is high.
// Reset: rst (synchronous) clears the fill count, state and strobe. Slot
//   contents are not cleared; only slots below the fill count are ever read.
// Stalls: none on the result side; the receiver takes every done word.
`default_nettype none
module can_id_learning_table_top #(
  parameter int TABLE_SLOTS = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire cil_pkg::cmd_t cmd,
  output logic               busy,
  output logic               done,
  output cil_pkg::rsp_t      rsp
);
  import cil_pkg::*;

  // fill count and sweep position share one width: 0..TABLE_SLOTS
  localparam int FW = $clog2(TABLE_SLOTS + 1);
  localparam int CW = (FW > INDEX_W) ? FW : INDEX_W;
  localparam logic [FW-1:0] LAST_POS = FW'(TABLE_SLOTS - 1);
  localparam logic [FW-1:0] FULL     = FW'(TABLE_SLOTS);

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_FIN} state_t;

  state_t        state;
  logic [FW-1:0] fill;
  logic [FW-1:0] pos;
  cmd_t          cmd_q;
  logic          hit;
  entry_t        cap;

  entry_t head;
  entry_t tail;
  logic   shift;
  logic   match;
  logic   at_index;
  logic   start_ext;
  rsp_t   rsp_next;
  logic   done_next;

  cil_ring #(.TABLE_SLOTS(TABLE_SLOTS)) u_ring (
    .clk   (clk),
    .shift (shift),
    .tail  (tail),
    .head  (head)
  );

  assign busy  = (state != S_IDLE);
  assign shift = (state == S_SWEEP);

  // extended frames never enter the ring
  assign start_ext = (cmd.kind == KIND_FRAME) && cmd.frame_extended;

  // head slot holds logical index pos; only filled slots take part in search
  assign match    = (cmd_q.kind == KIND_FRAME) && (pos < fill) &&
                    (head.ident == cmd_q.frame_ident);
  assign at_index = (CW'(pos) == CW'(cmd_q.read_index));

  always_comb begin
    tail = head;
    if (match) begin
      tail.length  = cmd_q.frame_length;
      tail.payload = cmd_q.frame_payload;
      tail.hits    = head.hits + 1'b1;
    end else if ((cmd_q.kind == KIND_FRAME) && (pos == fill)) begin
      // tentative append into the first free slot; it only becomes
      // visible if the sweep ends without a hit
      tail.ident   = cmd_q.frame_ident;
      tail.length  = cmd_q.frame_length;
      tail.payload = cmd_q.frame_payload;
      tail.hits    = HITS_FIRST;
    end
  end

  // result word for the item that finishes in this cycle
  always_comb begin
    rsp_next              = '0;
    done_next             = 1'b0;
    rsp_next.entries_used = USED_W'(fill);
    if (state == S_IDLE) begin
      done_next        = start && start_ext;
      rsp_next.dropped = 1'b1;
    end else if (state == S_FIN) begin
      done_next = 1'b1;
      if (cmd_q.kind == KIND_FRAME) begin
        if (hit) begin
          rsp_next.updated_existing = 1'b1;
        end else if (fill < FULL) begin
          rsp_next.added_new    = 1'b1;
          rsp_next.entries_used = USED_W'(fill + 1'b1);
        end else begin
          rsp_next.dropped = 1'b1;
        end
      end else if (CW'(cmd_q.read_index) < CW'(fill)) begin
        rsp_next.read_valid    = 1'b1;
        rsp_next.entry_ident   = cap.ident;
        rsp_next.entry_length  = cap.length;
        rsp_next.entry_payload = cap.payload;
        rsp_next.entry_hits    = cap.hits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      done  <= 1'b0;
    end else begin
      done <= done_next;
      if (done_next) begin
        rsp <= rsp_next;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            hit   <= 1'b0;
            pos   <= '0;
            if (!start_ext) begin
              state <= S_SWEEP;
            end
          end
        end
        S_SWEEP: begin
          if (match) begin
            hit <= 1'b1;
          end
          if (at_index) begin
            cap <= head;
          end
          pos <= pos + 1'b1;
          if (pos == LAST_POS) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= S_IDLE;
          if (rsp_next.added_new) begin
            fill <= fill + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // at most one outcome flag per result word
  a_flags_onehot: assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot0({rsp.added_new, rsp.updated_existing, rsp.dropped, rsp.read_valid}))
    else $error("more than one outcome flag set");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL)
    else $error("fill count beyond table size");

  a_append_counts: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.added_new) |-> (fill == FW'($past(fill) + 1'b1)))
    else $error("append without fill count step");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result issued while still sweeping");

  a_sweep_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !((cmd.kind == KIND_FRAME) && cmd.frame_extended)) |=> busy)
    else $error("searchable item did not start a sweep");

endmodule
`default_nettype wire

### tb/can_id_learning_table_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the CAN identifier learning table: mirrors the table, checks each result word.
module can_id_learning_table_checker #(
  parameter int SLOTS = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  cil_pkg::cmd_t cmd,
  input  logic          done,
  input  cil_pkg::rsp_t rsp,
  output int            fail_count,
  output int            outstanding
);
  import cil_pkg::*;

  logic [IDENT_W-1:0]   ident_mem   [SLOTS];
  logic [LENGTH_W-1:0]  length_mem  [SLOTS];
  logic [PAYLOAD_W-1:0] payload_mem [SLOTS];
  logic [HITS_W-1:0]    hits_mem    [SLOTS];
  int                   fill;
  rsp_t                 due_q[$];

  // Apply one command to the mirror table and return the word it should give.
  function automatic rsp_t learn_or_read(input cmd_t c);
    rsp_t r;
    int   slot;
    r = '0;
    slot = -1;
    if (c.kind == KIND_FRAME) begin
      if (c.frame_extended) begin
        r.dropped = 1'b1;
      end else begin
        for (int i = 0; i < fill; i++)
          if (slot < 0 && ident_mem[i] == c.frame_ident) slot = i;
        if (slot >= 0) begin
          length_mem[slot]  = c.frame_length;
          payload_mem[slot] = c.frame_payload;
          hits_mem[slot]    = hits_mem[slot] + 1'b1;
          r.updated_existing = 1'b1;
        end else if (fill < SLOTS) begin
          ident_mem[fill]   = c.frame_ident;
          length_mem[fill]  = c.frame_length;
          payload_mem[fill] = c.frame_payload;
          hits_mem[fill]    = HITS_FIRST;
          fill++;
          r.added_new = 1'b1;
        end else begin
          r.dropped = 1'b1;
        end
      end
    end else if (int'(c.read_index) < fill) begin
      r.read_valid    = 1'b1;
      r.entry_ident   = ident_mem[c.read_index];
      r.entry_length  = length_mem[c.read_index];
      r.entry_payload = payload_mem[c.read_index];
      r.entry_hits    = hits_mem[c.read_index];
    end
    r.entries_used = USED_W'(fill);
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [63:0] want_v,
                               input logic [63:0] got_v);
    if (got_v !== want_v) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      fill = 0;
      due_q.delete();
    end else begin
      // retire before accept: done and the next take can share an edge
      if (done) begin
        if (due_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result word with none pending, got %h", $time, rsp);
        end else begin
          want = due_q.pop_front();
          compare_field("added_new",        want.added_new,        rsp.added_new);
          compare_field("updated_existing", want.updated_existing, rsp.updated_existing);
          compare_field("dropped",          want.dropped,          rsp.dropped);
          compare_field("read_valid",       want.read_valid,       rsp.read_valid);
          compare_field("entry_ident",      want.entry_ident,      rsp.entry_ident);
          compare_field("entry_length",     want.entry_length,     rsp.entry_length);
          compare_field("entry_payload",    want.entry_payload,    rsp.entry_payload);
          compare_field("entry_hits",       want.entry_hits,       rsp.entry_hits);
          compare_field("entries_used",     want.entries_used,     rsp.entries_used);
        end
      end
      if (start && !busy) due_q.push_back(learn_or_read(cmd));
    end
    outstanding = due_q.size();
  end

endmodule

### tb/tb_can_id_learning_table_top.sv
`timescale 1ns / 1ps
// Testbench top for the CAN identifier learning table: command stimulus and verdict.
module tb_can_id_learning_table_top;
  import cil_pkg::*;

  localparam int     SLOTS        = 256;
  localparam int     PHASE_WORDS  = 326;      // words per phase
  localparam int     PHASES       = 5;
  localparam longint CYCLE_LIMIT  = 2_000_000; // ~4x the slowest expected run

  logic   clk   = 1'b0;
  logic   rst   = 1'b1;
  logic   start = 1'b0;
  cmd_t   cmd   = '0;
  logic   busy;
  logic   done;
  rsp_t   rsp;
  int     fail_count;
  int     outstanding;
  longint cycles = 0;
  int     idle_pct = 0;

  // Identifiers in first-seen order; the first SLOTS of them are the stored ones,
  // later ones only ever hit the full-table drop.
  logic [IDENT_W-1:0] learned_q[$];
  bit                 seen [2048];

  // Idle percentage per phase: none, heavy, light, heavy, none.
  int phase_idle [PHASES] = '{0, 82, 22, 82, 0};

  always #6 clk = ~clk;

  can_id_learning_table_top #(.TABLE_SLOTS(SLOTS)) i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
  );

  can_id_learning_table_checker #(.SLOTS(SLOTS)) i_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .done        (done),
    .rsp         (rsp),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Watchdog: a hung handshake or a lost result word ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[can_id_learning_table_top] ERROR");
      $finish;
    end
  end

  // Fully random command word; the fields a kind does not use stay as noise.
  function automatic cmd_t noise_word();
    logic [95:0] junk;
    junk = {$urandom, $urandom, $urandom};
    return junk[$bits(cmd_t)-1:0];
  endfunction

  function automatic cmd_t frame_word(input logic ext, input logic [IDENT_W-1:0] ident,
                                      input logic [LENGTH_W-1:0] len,
                                      input logic [PAYLOAD_W-1:0] payload);
    cmd_t c;
    c = noise_word();
    c.kind           = KIND_FRAME;
    c.frame_extended = ext;
    c.frame_ident    = ident;
    c.frame_length   = len;
    c.frame_payload  = payload;
    return c;
  endfunction

  function automatic cmd_t read_word(input logic [INDEX_W-1:0] index);
    cmd_t c;
    c = noise_word();
    c.kind       = KIND_READ;
    c.read_index = index;
    return c;
  endfunction

  // Random traffic: mostly frames that refresh known identifiers or learn new
  // ones, reads mostly inside the filled range, a few extended frames.
  function automatic cmd_t random_word();
    cmd_t c;
    int   r;
    int   stored;
    c = noise_word();
    r = $urandom_range(99);
    stored = (learned_q.size() < SLOTS) ? learned_q.size() : SLOTS;
    if (r < 6) begin
      c.kind           = KIND_FRAME;
      c.frame_extended = 1'b1;
    end else if (r < 68) begin
      c.kind           = KIND_FRAME;
      c.frame_extended = 1'b0;
      if (stored > 0 && r < 42) c.frame_ident = learned_q[$urandom_range(stored - 1)];
    end else begin
      c.kind = KIND_READ;
      if (stored > 0 && $urandom_range(9) < 8)
        c.read_index = INDEX_W'($urandom_range(stored - 1));
    end
    return c;
  endfunction

  // Present one command word. Idle cycles (start low, noise on cmd) come first;
  // half the time they start only once the table is free, so gaps land both
  // inside the ring pass and after it. Returns after the edge that took the word.
  task automatic send_word(input cmd_t c);
    if (idle_pct > 0 && $urandom_range(1) == 1) begin
      while (busy) begin
        start <= 1'b0;
        cmd   <= noise_word();
        @(posedge clk);
      end
    end
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      cmd   <= noise_word();
      @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    if (c.kind == KIND_FRAME && !c.frame_extended && !seen[c.frame_ident]) begin
      seen[c.frame_ident] = 1'b1;
      learned_q.push_back(c.frame_ident);
    end
  endtask

  initial begin
    cmd_t w;
    int   counted;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-table reads, extended drops, field extremes, hits and misses,
    // reads at and past the fill boundary.
    send_word(read_word(8'h00));
    send_word(read_word(8'hFF));
    send_word(frame_word(1'b1, 11'h7FF, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF));
    send_word(frame_word(1'b0, 11'h000, 4'h0, 64'h0));
    send_word(frame_word(1'b0, 11'h7FF, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF));
    send_word(frame_word(1'b0, 11'h000, 4'hF, 64'hAAAA_AAAA_AAAA_AAAA));
    send_word(frame_word(1'b0, 11'h555, 4'h5, 64'h5555_5555_5555_5555));
    send_word(frame_word(1'b0, 11'h2AA, 4'hA, 64'h0123_4567_89AB_CDEF));
    // extended frame whose identifier is already stored: still dropped
    send_word(frame_word(1'b1, 11'h000, 4'h3, 64'hDEAD_BEEF_0000_0001));
    send_word(read_word(8'h00));
    send_word(read_word(8'h01));
    send_word(read_word(8'h02));
    send_word(read_word(8'h03));
    send_word(read_word(8'h04));  // equal to fill count: invalid
    send_word(read_word(8'h80));
    send_word(read_word(8'hFF));
    send_word(frame_word(1'b0, 11'h7FF, 4'h0, 64'h0));
    send_word(read_word(8'h01));

    // Random phases; the table fills partway through and stays full, so later
    // phases see full-table drops alongside refreshes of stored identifiers.
    for (int p = 0; p < PHASES; p++) begin
      idle_pct = phase_idle[p];
      counted = 0;
      while (counted < PHASE_WORDS) begin
        w = random_word();
        send_word(w);
        counted++;
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2 * SLOTS) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[can_id_learning_table_top] OK");
    end else begin
      $display("[can_id_learning_table_top] ERROR");
    end
    $finish;
  end

endmodule
